// File: rtl/fat_chain_extent_builder_defines.svh
// Assertion macros used by the checker file of fat_chain_extent_builder.
// No dependencies; include by bare file name.
`ifndef FAT_CHAIN_EXTENT_BUILDER_DEFINES_SVH
`define FAT_CHAIN_EXTENT_BUILDER_DEFINES_SVH

// Concurrent assertion, masked while reset is high.
`define FCX_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds through reset.
`define FCX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/fcx_pkg.sv
// Shared types and constants for the FAT chain extent builder.
// No dependencies.
package fcx_pkg;

   localparam int ClusterWidth = 28;
   localparam int StepWidth    = ClusterWidth + 1;

   typedef enum logic [1:0] {
      REC_EXTENT = 2'd0,
      REC_FINAL  = 2'd1,
      REC_EMPTY  = 2'd2,
      REC_LOOP   = 2'd3
   } record_kind_type;

   typedef enum logic [1:0] {
      FAT_12 = 2'd0,
      FAT_16 = 2'd1,
      FAT_32 = 2'd2
   } fat_kind_type;

   // Register indexes on the csr port
   localparam logic CSR_FAT_KIND      = 1'b0;
   localparam logic CSR_CLUSTER_COUNT = 1'b1;

   // End-of-chain thresholds
   localparam logic [ClusterWidth-1:0] EOC_FAT12 = 28'h0000FF8;
   localparam logic [ClusterWidth-1:0] EOC_FAT16 = 28'h000FFF8;
   localparam logic [ClusterWidth-1:0] EOC_FAT32 = 28'hFFFFFF8;

   localparam logic [ClusterWidth-1:0] FIRST_DATA_CLUSTER = 28'd2;

   typedef struct packed {
      record_kind_type         kind;
      logic [ClusterWidth-1:0] lcn;
      logic [ClusterWidth-1:0] vcn;
      logic [ClusterWidth-1:0] so_far;
      logic                    last;
   } rsp_type;

endpackage

// File: rtl/fat_chain_extent_builder.sv
// FAT chain extent builder: an accepted request's result is registered in the result
// register, or in the skid register while that one holds. Throughput: one request per
// cycle while req_stall is low, set by the walk state update (open run, VCN, tallies)
// from the incoming cluster number. A two-entry output (result register plus skid register)
// drives req_stall from the skid valid flop, high while a result is parked behind a stalled one.
// Reset (synchronous, active high) clears the walk, config registers and queue.
module fat_chain_extent_builder (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_write_enable,
   input  logic                                csr_index,
   input  logic [fcx_pkg::ClusterWidth-1:0]    csr_write_data,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_start_chain,
   input  logic [fcx_pkg::ClusterWidth-1:0]    req_cluster_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_record_kind,
   output logic [fcx_pkg::ClusterWidth-1:0]    rsp_extent_lcn,
   output logic [fcx_pkg::ClusterWidth-1:0]    rsp_next_vcn,
   output logic [fcx_pkg::ClusterWidth-1:0]    rsp_clusters_so_far,
   output logic                                rsp_last_of_item
);

   localparam int CW = fcx_pkg::ClusterWidth;
   localparam int SW = fcx_pkg::StepWidth;

   // Configuration registers
   logic [1:0]    fat_kind_ff;
   logic [CW-1:0] cluster_count_ff;

   // Walk state
   logic [CW-1:0] run_first_ff, run_first_in;
   logic [CW-1:0] run_last_ff, run_last_in;
   logic [CW-1:0] vcn_total_ff, vcn_total_in;
   logic [CW-1:0] cluster_tally_ff, cluster_tally_in;
   logic [SW-1:0] step_tally_ff, step_tally_in;
   logic          walk_active_ff, walk_active_in;

   // Output queue: result register and skid register
   logic             rsp_valid_ff, skid_valid_ff;
   fcx_pkg::rsp_type rsp_ff, skid_ff;

   // Result of the current request
   logic             res_valid;
   fcx_pkg::rsp_type res;

   logic          accept;
   logic          pop;

   // Effective state: a chain start clears the walk before the step
   logic [CW-1:0] first_eff, last_eff, vcn_eff, tally_eff;
   logic [SW-1:0] step_eff;
   logic          active_eff;

   logic [SW-1:0] limit;
   logic [CW-1:0] eoc;
   logic          is_loop, is_end, run_open, breaks_run;
   logic [CW-1:0] closed_vcn;   // VCN after closing the open run
   logic [CW-1:0] tally_inc;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign pop       = rsp_valid_ff && !rsp_stall;

   always_comb begin
      unique case (fcx_pkg::fat_kind_type'(fat_kind_ff))
         fcx_pkg::FAT_12: eoc = fcx_pkg::EOC_FAT12;
         fcx_pkg::FAT_16: eoc = fcx_pkg::EOC_FAT16;
         default:         eoc = fcx_pkg::EOC_FAT32;   // unused code acts as FAT32
      endcase
   end

   assign limit = {1'b0, cluster_count_ff} + SW'(1);

   assign first_eff  = req_start_chain ? req_cluster_value : run_first_ff;
   assign last_eff   = req_start_chain ? '0 : run_last_ff;
   assign vcn_eff    = req_start_chain ? '0 : vcn_total_ff;
   assign tally_eff  = req_start_chain ? '0 : cluster_tally_ff;
   assign step_eff   = req_start_chain ? '0 : step_tally_ff;
   assign active_eff = req_start_chain || walk_active_ff;

   assign is_loop    = step_eff >= limit;
   // end-of-chain mark or a cluster number outside 2 .. cluster_count+1
   assign is_end     = (req_cluster_value >= eoc)
                    || (req_cluster_value < fcx_pkg::FIRST_DATA_CLUSTER)
                    || ({1'b0, req_cluster_value} > limit);
   assign run_open   = last_eff != '0;
   assign breaks_run = run_open && (req_cluster_value != last_eff + CW'(1));
   assign closed_vcn = vcn_eff + (last_eff - first_eff) + CW'(1);
   assign tally_inc  = tally_eff + CW'(1);

   always_comb begin
      run_first_in     = first_eff;
      run_last_in      = last_eff;
      vcn_total_in     = vcn_eff;
      cluster_tally_in = tally_eff;
      step_tally_in    = step_eff;
      walk_active_in   = active_eff;
      res_valid        = 1'b0;
      res.kind         = fcx_pkg::REC_EXTENT;
      res.lcn          = '0;
      res.vcn          = vcn_eff;
      res.so_far       = tally_eff;
      res.last         = 1'b1;

      if (active_eff) begin
         if (is_loop) begin
            // walk too long: drop the open run
            walk_active_in = 1'b0;
            res_valid      = 1'b1;
            res.kind       = fcx_pkg::REC_LOOP;
         end else if (is_end) begin
            walk_active_in = 1'b0;
            res_valid      = 1'b1;
            if (run_open) begin
               vcn_total_in = closed_vcn;
               res.kind     = fcx_pkg::REC_FINAL;
               res.lcn      = first_eff - fcx_pkg::FIRST_DATA_CLUSTER;
               res.vcn      = closed_vcn;
            end else begin
               res.kind     = fcx_pkg::REC_EMPTY;
            end
         end else begin
            cluster_tally_in = tally_inc;
            step_tally_in    = step_eff + SW'(1);
            run_last_in      = req_cluster_value;
            if (breaks_run) begin
               // discontinuity closes the run; the new cluster opens the next
               vcn_total_in = closed_vcn;
               run_first_in = req_cluster_value;
               res_valid    = 1'b1;
               res.kind     = fcx_pkg::REC_EXTENT;
               res.lcn      = first_eff - fcx_pkg::FIRST_DATA_CLUSTER;
               res.vcn      = closed_vcn;
               res.so_far   = tally_inc;
               res.last     = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fat_kind_ff      <= '0;
         cluster_count_ff <= '0;
         run_first_ff     <= '0;
         run_last_ff      <= '0;
         vcn_total_ff     <= '0;
         cluster_tally_ff <= '0;
         step_tally_ff    <= '0;
         walk_active_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               fcx_pkg::CSR_FAT_KIND:      fat_kind_ff      <= csr_write_data[1:0];
               fcx_pkg::CSR_CLUSTER_COUNT: cluster_count_ff <= csr_write_data;
               default: ;
            endcase
         end

         if (accept) begin
            run_first_ff     <= run_first_in;
            run_last_ff      <= run_last_in;
            vcn_total_ff     <= vcn_total_in;
            cluster_tally_ff <= cluster_tally_in;
            step_tally_ff    <= step_tally_in;
            walk_active_ff   <= walk_active_in;
         end

         // skid is only loaded while the result register holds, and
         // requests stop while the skid is full, so it never overflows
         if (!rsp_valid_ff || pop) begin
            if (skid_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               rsp_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff  <= accept && res_valid;
               rsp_ff        <= res;
            end
         end else if (accept && res_valid) begin
            skid_valid_ff <= 1'b1;
            skid_ff       <= res;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_record_kind     = rsp_ff.kind;
   assign rsp_extent_lcn      = rsp_ff.lcn;
   assign rsp_next_vcn        = rsp_ff.vcn;
   assign rsp_clusters_so_far = rsp_ff.so_far;
   assign rsp_last_of_item    = rsp_ff.last;

endmodule

// File: rtl/fcx_checker.sv
// Port-level checker for fat_chain_extent_builder, bound to the top level.
// Depends on fcx_pkg and fat_chain_extent_builder_defines.svh.
`include "fat_chain_extent_builder_defines.svh"

module fcx_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [1:0]                       rsp_record_kind,
   input logic [fcx_pkg::ClusterWidth-1:0] rsp_extent_lcn,
   input logic                             rsp_last_of_item
);

   `FCX_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid,
      "response valid after reset")
   `FCX_ASSERT(a_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid,
      "stalled response dropped")
   `FCX_ASSERT(a_last_kind, clock, reset,
      rsp_valid |-> (rsp_last_of_item == (rsp_record_kind != fcx_pkg::REC_EXTENT)),
      "last flag disagrees with kind")
   `FCX_ASSERT(a_no_lcn, clock, reset,
      rsp_valid && (rsp_record_kind == fcx_pkg::REC_EMPTY
                    || rsp_record_kind == fcx_pkg::REC_LOOP) |-> rsp_extent_lcn == '0,
      "lcn set without extent")
   `FCX_ASSERT(a_stall_src, clock, reset, req_stall |-> rsp_valid,
      "request stalled with empty output")

endmodule

bind fat_chain_extent_builder fcx_checker u_fcx_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_record_kind  (rsp_record_kind),
   .rsp_extent_lcn   (rsp_extent_lcn),
   .rsp_last_of_item (rsp_last_of_item)
);
